// ===== rtl/fpm_pkg.sv =====
// Shared types and constants for the frame pacer / fps meter.
// No dependencies; compile first.
package fpm_pkg;

  localparam int TIME_BITS = 32;
  localparam int CNT_BITS  = 32;
  localparam int FPS_BITS  = 16;
  localparam int TGT_BITS  = 10;
  localparam int WIN_BITS  = 16;
  localparam int CFG_BITS  = 16;
  localparam int PROD_BITS = CNT_BITS + TGT_BITS;

  localparam logic [TGT_BITS-1:0] MS_PER_S    = 10'd1000;
  localparam logic [TGT_BITS-1:0] DEFAULT_FPS = 10'd60;
  localparam logic [1:0]          TOL_MS      = 2'd3;
  localparam logic [WIN_BITS-1:0] WINDOW_RST  = 16'd500;

  typedef logic [1:0]           cfg_idx_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [FPS_BITS-1:0]  fps_t;

  localparam cfg_idx_t CFG_TARGET_FPS = 2'd0;
  localparam cfg_idx_t CFG_WINDOW_MS  = 2'd1;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

endpackage

// ===== rtl/fpm_in_if.sv =====
// Input event channel: valid/ready plus kind and timestamp.
// Depends on fpm_pkg.
interface fpm_in_if;
  import fpm_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  time_t now_ms;

  modport source (output valid, output kind, output now_ms, input ready);
  modport sink   (input valid, input kind, input now_ms, output ready);
endinterface

// ===== rtl/fpm_out_if.sv =====
// Result channel: valid/ready plus capture flag and fps report.
// Depends on fpm_pkg.
interface fpm_out_if;
  import fpm_pkg::*;

  logic valid;
  logic ready;
  logic capture;
  logic fps_valid;
  fps_t actual_fps;
  fps_t stamped_fps;

  modport source (output valid, output capture, output fps_valid, output actual_fps,
                  output stamped_fps, input ready);
  modport sink   (input valid, input capture, input fps_valid, input actual_fps,
                  input stamped_fps, output ready);
endinterface

// ===== rtl/frame_pacer_fps_meter.sv =====
// Frame pacer with fps meter, top level.
// Depends on fpm_pkg, fpm_in_if, fpm_out_if.
//
// Takes one timestamped event word at a time and returns exactly one result word per
// event. A capture query (kind 0) runs the fixed-timestep accumulator and answers with
// capture; a frame event (kind 1) counts a rendered frame and, once window_ms has
// elapsed, reports rendered and captured fps. All division goes through one shared
// 16-step restoring divider. A query other than the first ever makes one divider pass;
// a frame event that reports makes two (one per rate, a saturating rate skips its
// pass), and one that does not report makes none. in_ch.ready is high only while the
// sequencer is idle and no finished result is waiting for the output register; a
// result held in the output register does not hold off the next word.
// Configuration writes are taken at any time but must only be issued while idle.
module frame_pacer_fps_meter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  fpm_pkg::cfg_idx_t        cfg_idx,
  input  logic [fpm_pkg::CFG_BITS-1:0] cfg_wdata,
  fpm_in_if.sink                   in_ch,
  fpm_out_if.source                out_ch
);
  import fpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_FCHK, S_MUL, S_DLD, S_DIV, S_ACC, S_NEXT
  } state_t;

  localparam int QWORD = FPS_BITS;

  function automatic cnt_t sat_inc(cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // config
  logic [TGT_BITS-1:0] target_r;
  logic [WIN_BITS-1:0] window_r;

  // pacer / meter state
  state_t              state_r;
  logic                out_pend_r;
  time_t               last_r;
  logic                qseen_r;
  cnt_t                acc_r;
  cnt_t                rcnt_r;
  cnt_t                ccnt_r;
  time_t               wstart_r;
  logic                wstarted_r;
  time_t               now_r;
  time_t               span_r;     // dt for queries, elapsed for frames
  logic                kind_r;
  logic                phase_r;    // 0: rendered fps, 1: captured fps

  // shared divider
  logic [PROD_BITS-1:0] prod_r;
  logic [CNT_BITS-1:0]  rem_r;
  logic [QWORD-1:0]     lo_r;
  logic [QWORD-1:0]     quo_r;
  logic [CNT_BITS-1:0]  div_r;
  logic [3:0]           iter_r;

  // result being built, and the output register
  logic res_cap_r, res_fv_r;
  fps_t res_act_r, res_stp_r;
  logic out_cap_r, out_fv_r;
  fps_t out_act_r, out_stp_r;
  logic out_valid_r;

  logic                 in_acc;
  logic                 out_free;
  time_t                span_q, span_f;
  logic [CNT_BITS:0]    rem_sh, rem_sub;
  logic                 div_ge;
  logic [CNT_BITS-1:0]  rem_new;
  logic [CNT_BITS:0]    acc_sum;
  cnt_t                 acc_sat;
  logic [QWORD-1:0]     intv;
  logic [QWORD+1:0]     intv3;
  logic                 hit, over;
  cnt_t                 mul_op;
  logic [PROD_BITS-1:0] mul_res;
  logic                 fps_sat;

  assign in_ch.ready = (state_r == S_IDLE) && !out_pend_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.capture     = out_cap_r;
  assign out_ch.fps_valid   = out_fv_r;
  assign out_ch.actual_fps  = out_act_r;
  assign out_ch.stamped_fps = out_stp_r;

  always_comb begin
    span_q  = in_ch.now_ms - last_r;
    span_f  = wstarted_r ? (in_ch.now_ms - wstart_r) : '0;

    // one restoring divide step
    rem_sh  = {rem_r, lo_r[QWORD-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    div_ge  = (rem_sh >= {1'b0, div_r});
    rem_new = div_ge ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];

    // saturating accumulate
    acc_sum = {1'b0, acc_r} + {1'b0, span_r};
    acc_sat = acc_sum[CNT_BITS] ? '1 : acc_sum[CNT_BITS-1:0];

    // interval sits in the quotient after the divider pass
    intv  = quo_r;
    intv3 = {1'b0, intv, 1'b0} + {2'b00, intv};
    hit   = ({1'b0, acc_r} + {{(CNT_BITS-1){1'b0}}, TOL_MS})
            >= {{(CNT_BITS+1-QWORD){1'b0}}, intv};
    over  = acc_r > {{(CNT_BITS-QWORD-2){1'b0}}, intv3};

    mul_op  = phase_r ? ccnt_r : rcnt_r;
    mul_res = {{TGT_BITS{1'b0}}, mul_op} * {{CNT_BITS{1'b0}}, MS_PER_S};
    // quotient of at least 2^16 saturates without dividing
    fps_sat = {{(CNT_BITS-(PROD_BITS-QWORD)){1'b0}}, prod_r[PROD_BITS-1:QWORD]} >= span_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= '0;
      window_r    <= WINDOW_RST;
      last_r      <= '0;
      qseen_r     <= 1'b0;
      acc_r       <= '0;
      rcnt_r      <= '0;
      ccnt_r      <= '0;
      wstart_r    <= '0;
      wstarted_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_pend_r  <= 1'b0;
      phase_r     <= 1'b0;
      iter_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TARGET_FPS: target_r <= cfg_wdata[TGT_BITS-1:0];
          CFG_WINDOW_MS:  window_r <= cfg_wdata[WIN_BITS-1:0];
          default: ;
        endcase
      end

      // hand a finished result to the output register once it is free
      if (out_pend_r && out_free) begin
        out_valid_r <= 1'b1;
        out_cap_r   <= res_cap_r;
        out_fv_r    <= res_fv_r;
        out_act_r   <= res_act_r;
        out_stp_r   <= res_stp_r;
        out_pend_r  <= 1'b0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_cap_r <= 1'b0;
            res_fv_r  <= 1'b0;
            res_act_r <= '0;
            res_stp_r <= '0;
            kind_r    <= in_ch.kind;
            now_r     <= in_ch.now_ms;
            phase_r   <= 1'b0;
            if (in_ch.kind == KIND_QUERY) begin
              last_r <= in_ch.now_ms;
              if (!qseen_r) begin
                // first query always captures
                qseen_r    <= 1'b1;
                ccnt_r     <= sat_inc(ccnt_r);
                res_cap_r  <= 1'b1;
                out_pend_r <= 1'b1;
              end else begin
                span_r  <= span_q;
                state_r <= S_ADD;
              end
            end else begin
              if (!wstarted_r) wstart_r <= in_ch.now_ms;
              wstarted_r <= 1'b1;
              rcnt_r     <= sat_inc(rcnt_r);
              span_r     <= span_f;
              state_r    <= S_FCHK;
            end
          end
        end
        S_ADD: begin
          acc_r   <= acc_sat;
          rem_r   <= '0;
          lo_r    <= QWORD'(MS_PER_S);
          div_r   <= CNT_BITS'((target_r != '0) ? target_r : DEFAULT_FPS);
          iter_r  <= '0;
          state_r <= S_DIV;
        end
        S_FCHK: begin
          if (span_r >= {{(TIME_BITS-WIN_BITS){1'b0}}, window_r}) begin
            wstart_r <= now_r;
            if (span_r != '0) begin
              state_r <= S_MUL;
            end else begin
              // window closes with nothing to report
              rcnt_r     <= '0;
              ccnt_r     <= '0;
              out_pend_r <= 1'b1;
              state_r    <= S_IDLE;
            end
          end else begin
            out_pend_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        S_MUL: begin
          prod_r  <= mul_res;
          state_r <= S_DLD;
        end
        S_DLD: begin
          div_r <= span_r;
          if (fps_sat) begin
            quo_r   <= '1;
            state_r <= S_NEXT;
          end else begin
            rem_r   <= {{(CNT_BITS-(PROD_BITS-QWORD)){1'b0}}, prod_r[PROD_BITS-1:QWORD]};
            lo_r    <= prod_r[QWORD-1:0];
            iter_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_new;
          lo_r   <= {lo_r[QWORD-2:0], 1'b0};
          quo_r  <= {quo_r[QWORD-2:0], div_ge};
          iter_r <= iter_r + 1'b1;
          if (&iter_r) state_r <= (kind_r == KIND_QUERY) ? S_ACC : S_NEXT;
        end
        S_ACC: begin
          if (hit) begin
            res_cap_r <= 1'b1;
            ccnt_r    <= sat_inc(ccnt_r);
            if (over) acc_r <= '0;
            else if (acc_r >= {{(CNT_BITS-QWORD){1'b0}}, intv})
              acc_r <= acc_r - {{(CNT_BITS-QWORD){1'b0}}, intv};
            else acc_r <= '0;
          end
          out_pend_r <= 1'b1;
          state_r    <= S_IDLE;
        end
        S_NEXT: begin
          if (!phase_r) begin
            res_act_r <= quo_r;
            phase_r   <= 1'b1;
            state_r   <= S_MUL;
          end else begin
            res_stp_r  <= quo_r;
            res_fv_r   <= 1'b1;
            rcnt_r     <= '0;
            ccnt_r     <= '0;
            out_pend_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/frame_pacer_fps_meter_tb.sv =====
// Self-checking testbench for frame_pacer_fps_meter: capture pacing and fps reporting.
// Depends on fpm_pkg, fpm_in_if, fpm_out_if and the RTL top level.
// Directed pacing and register cases first, then paced random traffic and an output stall.
module frame_pacer_fps_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpm_pkg::*;

  // Run limit in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 400;
  // Quiet cycles after the last result before the verdict.
  localparam int TAIL_CYCLES = 100;
  // Register indexes past the defined list; writes there must be dropped.
  localparam cfg_idx_t CFG_SPARE_A = 2'd2;
  localparam cfg_idx_t CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic capture;
    logic fps_valid;
    fps_t actual_fps;
    fps_t stamped_fps;
  } pacer_word_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_idx;
  logic [CFG_BITS-1:0] cfg_wdata;

  fpm_in_if  in_if();
  fpm_out_if out_if();

  frame_pacer_fps_meter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block state, kept in step with every accepted word.
  // ---------------------------------------------------------------------------
  logic [TGT_BITS-1:0] tgt_fps   = '0;
  logic [WIN_BITS-1:0] win_ms    = WINDOW_RST;
  time_t               q_last    = '0;
  bit                  q_seen    = 1'b0;
  cnt_t                acc_ms    = '0;
  cnt_t                n_rendered = '0;
  cnt_t                n_captured = '0;
  time_t               win_start = '0;
  bit                  win_open  = 1'b0;

  pacer_word_t results_due[$];

  // Bookkeeping for the closing summary.
  int unsigned fails      = 0;
  int unsigned cycles     = 0;
  int unsigned n_queries  = 0;
  int unsigned n_frames   = 0;
  int unsigned n_reports  = 0;
  int unsigned n_captures = 0;
  int unsigned n_settings = 0;
  int unsigned n_holds    = 0;

  // Stimulus controls shared between processes.
  bit    calm     = 1'b0;   // no gaps on either side while set
  bit    hold_req = 1'b0;   // receiver takes a long hold-off, then clears this
  time_t stim_now = '0;

  function automatic cnt_t count_up(cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int unsigned FPS_MAX_V();
    return (1 << FPS_BITS) - 1;
  endfunction

  // count * 1000 / elapsed, clamped to the fps width
  function automatic fps_t fps_rate(cnt_t count, time_t elapsed);
    logic [63:0] q;
    q = (64'(count) * 64'(MS_PER_S)) / 64'(elapsed);
    return (q > 64'(FPS_MAX_V())) ? '1 : q[FPS_BITS-1:0];
  endfunction

  // Advance the shadow state by one event word and return the word the block owes.
  function automatic pacer_word_t next_pacer_word(logic kind, time_t now);
    pacer_word_t w;
    logic [63:0] interval;
    logic [63:0] sum;
    time_t       dt;
    time_t       elapsed;
    w = '0;
    if (kind == KIND_QUERY) begin
      if (!q_seen) begin
        // first query ever: capture, leave the accumulator alone
        q_seen     = 1'b1;
        q_last     = now;
        n_captured = count_up(n_captured);
        w.capture  = 1'b1;
      end else begin
        dt       = now - q_last;
        interval = 64'(MS_PER_S) / ((tgt_fps != '0) ? 64'(tgt_fps) : 64'(DEFAULT_FPS));
        q_last   = now;
        sum      = 64'(acc_ms) + 64'(dt);
        acc_ms   = (sum > 64'(cnt_t'('1))) ? '1 : sum[CNT_BITS-1:0];
        if (64'(acc_ms) + 64'(TOL_MS) >= interval) begin
          w.capture = 1'b1;
          if (64'(acc_ms) > interval * 3)
            acc_ms = '0;                           // lagging far behind: resync
          else if (64'(acc_ms) >= interval)
            acc_ms = acc_ms - interval[CNT_BITS-1:0];
          else
            acc_ms = '0;                           // caught inside tolerance
          n_captured = count_up(n_captured);
        end
      end
    end else begin
      if (!win_open) begin
        win_open  = 1'b1;
        win_start = now;
      end
      n_rendered = count_up(n_rendered);
      elapsed    = now - win_start;
      if (elapsed >= 32'(win_ms)) begin
        if (elapsed != '0) begin
          w.fps_valid   = 1'b1;
          w.actual_fps  = fps_rate(n_rendered, elapsed);
          w.stamped_fps = fps_rate(n_captured, elapsed);
        end
        win_start  = now;
        n_rendered = '0;
        n_captured = '0;
      end
    end
    return w;
  endfunction

  // Random gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_req = 1'b0;
        n_holds++;
      end
      stall = calm ? 0 : pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Every accepted result word is compared with the oldest owed word.
  always @(posedge clk) begin : check_results
    pacer_word_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing owed");
        fails++;
      end else begin
        want = results_due.pop_front();
        if (out_if.capture !== want.capture) begin
          $error("capture: expected %0d, got %0d", want.capture, out_if.capture);
          fails++;
        end
        if (out_if.fps_valid !== want.fps_valid) begin
          $error("fps_valid: expected %0d, got %0d", want.fps_valid, out_if.fps_valid);
          fails++;
        end
        if (out_if.actual_fps !== want.actual_fps) begin
          $error("actual_fps: expected %0d, got %0d", want.actual_fps, out_if.actual_fps);
          fails++;
        end
        if (out_if.stamped_fps !== want.stamped_fps) begin
          $error("stamped_fps: expected %0d, got %0d", want.stamped_fps, out_if.stamped_fps);
          fails++;
        end
        if (want.capture) n_captures++;
        if (want.fps_valid) n_reports++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one event word; valid stays up across back-to-back words.
  task automatic send_word(logic kind, time_t now);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= kind;
    in_if.now_ms <= now;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    results_due.push_back(next_pacer_word(kind, now));
    if (kind == KIND_QUERY) n_queries++;
    else n_frames++;
  endtask

  // Drop valid and wait for every owed word; the block is idle afterwards.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  // Register write, only issued while the block is idle.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_TARGET_FPS) tgt_fps = data[TGT_BITS-1:0];
    else if (idx == CFG_WINDOW_MS) win_ms = data[WIN_BITS-1:0];
  endtask

  task automatic set_rates(logic [CFG_BITS-1:0] fps, logic [CFG_BITS-1:0] window);
    drain();
    write_reg(CFG_TARGET_FPS, fps);
    write_reg(CFG_WINDOW_MS, window);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: target 0 -> 60 fps (16 ms interval), 500 ms window.
  task automatic test_directed_pacing();
    send_word(KIND_FRAME, 32'd100);          // first frame opens the window
    send_word(KIND_QUERY, 32'd100);          // first query always captures
    send_word(KIND_QUERY, 32'd116);          // exactly one interval
    send_word(KIND_QUERY, 32'd118);          // short of interval minus tolerance
    send_word(KIND_QUERY, 32'd129);          // inside tolerance, floors at zero
    send_word(KIND_QUERY, 32'd200);          // more than three intervals: clear
    send_word(KIND_FRAME, 32'd600);          // window exactly reached: report
    send_word(KIND_QUERY, 32'd205);          // leaves a small remainder
    send_word(KIND_QUERY, 32'd204);          // backwards step: dt wraps, acc saturates
    send_word(KIND_FRAME, 32'hFFFF_FFFF);    // huge elapsed, fps rounds to zero
    send_word(KIND_FRAME, 32'd5);            // elapsed across the wrap
    send_word(KIND_FRAME, 32'hAAAA_5555);
  endtask

  // Register extremes, high bits of the target write dropped, spare indexes ignored.
  task automatic test_register_extremes();
    drain();
    write_reg(CFG_TARGET_FPS, 16'hFFFF);     // 1023 -> zero interval
    n_settings++;
    send_word(KIND_QUERY, 32'd5000);
    send_word(KIND_QUERY, 32'd5000);
    drain();
    write_reg(CFG_TARGET_FPS, 16'd1);        // 1000 ms interval
    send_word(KIND_QUERY, 32'd5900);
    send_word(KIND_QUERY, 32'd5997);         // tolerance edge
    send_word(KIND_QUERY, 32'd9000);         // lag beyond three intervals
    drain();
    write_reg(CFG_TARGET_FPS, 16'd1000);     // 1 ms interval
    write_reg(CFG_WINDOW_MS, 16'd0);
    send_word(KIND_QUERY, 32'd9001);
    send_word(KIND_FRAME, 32'd9001);
    send_word(KIND_FRAME, 32'd9001);         // zero window, zero elapsed: silent close
    drain();
    write_reg(CFG_WINDOW_MS, 16'd1);
    write_reg(CFG_SPARE_A, 16'h1234);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    send_word(KIND_FRAME, 32'd9002);
    send_word(KIND_QUERY, 32'd9003);
    drain();
    write_reg(CFG_WINDOW_MS, 16'hFFFF);
    send_word(KIND_FRAME, 32'd9004);
    send_word(KIND_FRAME, 32'd9004 + 32'd65535);
    stim_now = 32'd9004 + 32'd65535;
  endtask

  // Mostly paced traffic with random content; some jumps, rewinds and same-time bursts.
  task automatic test_random_traffic(int n);
    int   sent;
    int   r;
    int   burst;
    logic kind;
    sent = 0;
    while (sent < n) begin
      if (sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 92) begin
        if (r < 80) stim_now += $urandom_range(0, 24);
        else if (r < 85) stim_now += $urandom;
        else if (r < 89) stim_now -= $urandom_range(1, 60);
        else stim_now = $urandom;
        kind = $urandom_range(0, 1) ? KIND_FRAME : KIND_QUERY;
        send_word(kind, stim_now);
        sent++;
      end else begin
        // many words at one timestamp: can drive the fps figures to saturation
        stim_now += $urandom_range(1, 4);
        burst = $urandom_range(40, 160);
        repeat (burst) begin
          kind = $urandom_range(0, 1) ? KIND_FRAME : KIND_QUERY;
          send_word(kind, stim_now);
        end
        sent += burst;
      end
    end
    calm = 1'b0;
  endtask

  // Long receiver hold-off while words keep coming: the block must stall its input.
  task automatic test_output_backpressure();
    drain();
    hold_req = 1'b1;
    repeat (40) begin
      stim_now += $urandom_range(0, 20);
      send_word($urandom_range(0, 1) ? KIND_FRAME : KIND_QUERY, stim_now);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_TARGET_FPS;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.kind   = KIND_QUERY;
    in_if.now_ms = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_pacing();
    test_register_extremes();

    set_rates(16'd0, 16'd500);
    test_random_traffic(160);
    set_rates(16'd60, 16'd16);
    test_random_traffic(140);
    set_rates(16'd1, 16'd1);
    test_random_traffic(140);
    set_rates(16'd1000, 16'd65535);
    test_random_traffic(120);
    set_rates(16'd1023, 16'd0);
    test_random_traffic(120);
    set_rates(16'd1000, 16'd2);
    test_random_traffic(140);
    set_rates(16'($urandom_range(0, 1023)), 16'($urandom_range(1, 65535)));
    test_random_traffic(140);
    set_rates(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 40)));
    test_random_traffic(140);

    test_output_backpressure();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d queries and %0d frame events under %0d rate settings;",
             n_queries, n_frames, n_settings);
    $display("saw %0d captures, %0d fps reports, %0d output hold-offs.",
             n_captures, n_reports, n_holds);
    if (fails == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== frame_pacer_fps_meter.f =====
rtl/fpm_pkg.sv
rtl/fpm_in_if.sv
rtl/fpm_out_if.sv
rtl/frame_pacer_fps_meter.sv
tb/sv/frame_pacer_fps_meter_tb.sv
